@@ design/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design files.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/lrm_pkg.sv @@
// -----------------------------------------------------------------------------
// lrm_pkg
// Widths, register indexes and defaults of the labeled region moments unit.
// -----------------------------------------------------------------------------
package lrm_pkg;

  localparam int unsigned LabelW    = 8;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned AreaW     = 25;
  localparam int unsigned SumXW     = 35;
  localparam int unsigned SumYW     = 35;
  localparam int unsigned SumXxW    = 47;
  localparam int unsigned SumXyW    = 46;
  localparam int unsigned AccXyW    = 47;
  localparam int unsigned SumYyW    = 47;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = SizeW;

  localparam int unsigned MaxWidthDef   = 4096;
  localparam int unsigned MaxHeightDef  = 4096;
  localparam int unsigned FrameSizeInit = 4096;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LABEL  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

endpackage

@@ design/lrm_if.sv @@
// -----------------------------------------------------------------------------
// lrm_if
// Valid/ready channels for mask pixels in and moment results out.
// -----------------------------------------------------------------------------
interface lrm_mask_if import lrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LabelW-1:0] mask_value;

  modport source (output valid, output mask_value, input ready);
  modport sink   (input valid, input mask_value, output ready);
endinterface

interface lrm_moments_if import lrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AreaW-1:0]  area;
  logic [SumXW-1:0]  sum_x;
  logic [SumYW-1:0]  sum_y;
  logic [SumXxW-1:0] sum_xx;
  logic [SumXyW-1:0] sum_xy;
  logic [SumYyW-1:0] sum_yy;

  modport source (output valid, output area, output sum_x, output sum_y,
                  output sum_xx, output sum_xy, output sum_yy, input ready);
  modport sink   (input valid, input area, input sum_x, input sum_y,
                  input sum_xx, input sum_xy, input sum_yy, output ready);
endinterface

@@ design/labeled_region_moments_unit.sv @@
// -----------------------------------------------------------------------------
// labeled_region_moments_unit
// Raw second-order moments of one label value in a raster stream of mask bytes.
// -----------------------------------------------------------------------------
// The unit takes one mask byte per transfer in raster order and tracks the
// pixel position itself from the configured frame width and height (each
// clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT). Every pixel equal to the
// configured label adds to the area and to the sums of x, y, x*x, x*y and
// y*y, with (0,0) at the top left. The last pixel of a frame produces one
// result transfer carrying the six totals, and the accumulators start over.
// Throughput is one pixel per clock while input ready is high: position
// tracking and the label compare sit in the input stage, the three coordinate
// products in the second stage, and the accumulators in the third, so a
// frame's last pixel passes the stage A and stage B registers before its
// result is loaded into the output register. The output register holds a
// finished result while pixels of the next frame keep flowing; input ready
// drops only when another frame's last pixel reaches the accumulators before
// the earlier result has been taken. Configuration writes are meant for idle
// periods; changing the size mid-frame ends rows and the frame early once the
// counters reach the new size. There is no clearing pass after reset.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module labeled_region_moments_unit import lrm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lrm_mask_if.sink            mask_i,
  lrm_moments_if.source       moments_o
);

  // Counter widths follow the largest frame; the extra bit lets the compare
  // see a count equal to the size itself.
  localparam int unsigned XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned XCW = XW + 1;
  localparam int unsigned YCW = YW + 1;

  // Configuration registers.
  logic [LabelW-1:0] label_q;
  logic [SizeW-1:0]  width_q;
  logic [SizeW-1:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q  <= '0;
      width_q  <= SizeW'(FrameSizeInit);
      height_q <= SizeW'(FrameSizeInit);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LABEL:  label_q  <= cfg_data_i[LabelW-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range.
  logic [XCW-1:0] width_eff;
  logic [YCW-1:0] height_eff;

  always_comb begin
    if (width_q == '0) begin
      width_eff = XCW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      width_eff = XCW'(MAX_WIDTH);
    end else begin
      width_eff = XCW'(width_q);
    end
    if (height_q == '0) begin
      height_eff = YCW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      height_eff = YCW'(MAX_HEIGHT);
    end else begin
      height_eff = YCW'(height_q);
    end
  end

  // The whole pipeline advances together; it only holds when a frame result
  // is ready to leave the accumulators and the output register is still full.
  logic advance;
  logic accept;

  // Stage A: position tracking and label compare.
  logic          va_q;
  logic          match_a_q;
  logic          last_a_q;
  logic [XW-1:0] xa_q;
  logic [YW-1:0] ya_q;
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic          row_end;
  logic          frame_end;

  // Stage B: coordinate products of matching pixels, zero otherwise.
  logic            vb_q;
  logic            match_b_q;
  logic            last_b_q;
  logic [XW-1:0]   xb_q;
  logic [YW-1:0]   yb_q;
  logic [2*XW-1:0] xx_b_q;
  logic [XW+YW-1:0] xy_b_q;
  logic [2*YW-1:0] yy_b_q;

  // Stage C: accumulators and result register.
  logic [AreaW-1:0]  area_q;
  logic [SumXW-1:0]  sum_x_q;
  logic [SumYW-1:0]  sum_y_q;
  logic [SumXxW-1:0] sum_xx_q;
  logic [AccXyW-1:0] sum_xy_q;
  logic [SumYyW-1:0] sum_yy_q;

  logic [AreaW-1:0]  area_d;
  logic [SumXW-1:0]  sum_x_d;
  logic [SumYW-1:0]  sum_y_d;
  logic [SumXxW-1:0] sum_xx_d;
  logic [AccXyW-1:0] sum_xy_d;
  logic [SumYyW-1:0] sum_yy_d;

  logic              out_valid_q;
  logic [AreaW-1:0]  out_area_q;
  logic [SumXW-1:0]  out_sum_x_q;
  logic [SumYW-1:0]  out_sum_y_q;
  logic [SumXxW-1:0] out_sum_xx_q;
  logic [SumXyW-1:0] out_sum_xy_q;
  logic [SumYyW-1:0] out_sum_yy_q;

  logic frame_done;

  assign advance      = !(vb_q && last_b_q && out_valid_q && !moments_o.ready);
  assign accept       = mask_i.valid && advance;
  assign mask_i.ready = advance;

  // A row ends once the next column would reach the width, and the frame
  // ends on a row end once the next row would reach the height.
  assign row_end   = (XCW'(col_q) + XCW'(1)) >= width_eff;
  assign frame_end = row_end && ((YCW'(row_q) + YCW'(1)) >= height_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else if (advance) begin
      va_q <= accept;
      vb_q <= va_q;
      if (accept) begin
        if (frame_end) begin
          col_q <= '0;
          row_q <= '0;
        end else if (row_end) begin
          col_q <= '0;
          row_q <= row_q + YW'(1);
        end else begin
          col_q <= col_q + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (accept) begin
        match_a_q <= (mask_i.mask_value == label_q);
        last_a_q  <= frame_end;
        xa_q      <= col_q;
        ya_q      <= row_q;
      end
      match_b_q <= match_a_q;
      last_b_q  <= last_a_q;
      xb_q      <= match_a_q ? xa_q : '0;
      yb_q      <= match_a_q ? ya_q : '0;
      xx_b_q    <= match_a_q ? (2*XW)'(xa_q) * (2*XW)'(xa_q) : '0;
      xy_b_q    <= match_a_q ? (XW+YW)'(xa_q) * (XW+YW)'(ya_q) : '0;
      yy_b_q    <= match_a_q ? (2*YW)'(ya_q) * (2*YW)'(ya_q) : '0;
    end
  end

  // Running totals including the pixel in stage B; all wrap at their width.
  assign area_d   = area_q + AreaW'(match_b_q);
  assign sum_x_d  = sum_x_q + SumXW'(xb_q);
  assign sum_y_d  = sum_y_q + SumYW'(yb_q);
  assign sum_xx_d = sum_xx_q + SumXxW'(xx_b_q);
  assign sum_xy_d = sum_xy_q + AccXyW'(xy_b_q);
  assign sum_yy_d = sum_yy_q + SumYyW'(yy_b_q);

  assign frame_done = advance && vb_q && last_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q      <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_xx_q    <= '0;
      sum_xy_q    <= '0;
      sum_yy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance && vb_q) begin
        if (last_b_q) begin
          area_q   <= '0;
          sum_x_q  <= '0;
          sum_y_q  <= '0;
          sum_xx_q <= '0;
          sum_xy_q <= '0;
          sum_yy_q <= '0;
        end else begin
          area_q   <= area_d;
          sum_x_q  <= sum_x_d;
          sum_y_q  <= sum_y_d;
          sum_xx_q <= sum_xx_d;
          sum_xy_q <= sum_xy_d;
          sum_yy_q <= sum_yy_d;
        end
      end
      if (frame_done) begin
        out_valid_q <= 1'b1;
      end else if (moments_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload is loaded only when a frame completes.
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      out_area_q   <= area_d;
      out_sum_x_q  <= sum_x_d;
      out_sum_y_q  <= sum_y_d;
      out_sum_xx_q <= sum_xx_d;
      out_sum_xy_q <= sum_xy_d[SumXyW-1:0];
      out_sum_yy_q <= sum_yy_d;
    end
  end

  assign moments_o.valid  = out_valid_q;
  assign moments_o.area   = out_area_q;
  assign moments_o.sum_x  = out_sum_x_q;
  assign moments_o.sum_y  = out_sum_y_q;
  assign moments_o.sum_xx = out_sum_xx_q;
  assign moments_o.sum_xy = out_sum_xy_q;
  assign moments_o.sum_yy = out_sum_yy_q;

  // Assertions.
  `ASSERT_RST(a_result_loaded, clk_i, rst_ni, frame_done |=> out_valid_q,
              "frame end did not load the result register")
  `ASSERT_RST(a_acc_cleared, clk_i, rst_ni,
              frame_done |=> (area_q == '0 && sum_x_q == '0 && sum_xy_q == '0),
              "accumulators not cleared after frame end")
  `ASSERT_RST(a_stall_blocks_input, clk_i, rst_ni,
              (vb_q && last_b_q && out_valid_q && !moments_o.ready) |-> !mask_i.ready,
              "input taken while a frame result is blocked")
  `ASSERT_RST(a_nomatch_area, clk_i, rst_ni,
              (advance && vb_q && !match_b_q && !last_b_q) |=> $stable(area_q),
              "area changed on a pixel that does not match")
  `ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |-> !out_valid_q,
                 "result valid during reset")

endmodule
